// ===== rtl/core/ibaw_pkg.sv =====
// Shared types and constants of the idle block allocator
`default_nettype none
package ibaw_pkg;
	localparam int CMD_W    = 1;
	localparam int IDX_W    = 10;
	localparam int FREE_W   = 11;
	localparam int STATUS_W = 2;
	localparam int WM_W     = 11;

	localparam logic [WM_W-1:0] WM_RESET = 11'd128;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE     = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_FAULT    = 2'd2,
		STAT_NOT_USED = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/ibaw_if.sv =====
// Request and response channel interfaces of the idle block allocator
`default_nettype none
interface ibaw_req_if;
	logic                      valid;
	logic                      ready;
	logic [ibaw_pkg::CMD_W-1:0] command;
	logic [ibaw_pkg::IDX_W-1:0] block_index;
	logic                      fault_hit;

	modport source (output valid, command, block_index, fault_hit, input ready);
	modport sink (input valid, command, block_index, fault_hit, output ready);
endinterface

interface ibaw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ibaw_pkg::STATUS_W-1:0] status;
	logic [ibaw_pkg::IDX_W-1:0]    granted_block;
	logic [ibaw_pkg::FREE_W-1:0]   free_blocks;
	logic                         gc_needed;

	modport source (output valid, status, granted_block, free_blocks, gc_needed, input ready);
	modport sink (input valid, status, granted_block, free_blocks, gc_needed, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/idle_block_allocator_watermark_unit.sv =====
// Idle block allocator: LIFO free stack, in-use bitmap and GC watermark
//
// Requests arrive on req (valid/ready); each is an allocate or a free.
// Every request yields exactly one response transfer on rsp carrying the
// status, the granted block, the free count and the GC flag.
// A request is taken only in the idle state: on accept the stack memory
// is read at the top slot and the bitmap at the block index; once the
// response slot is free, the execute step writes back the stack (on a
// free) and the bitmap (on a grant or a free) and loads the response
// register. The next request waits for this read/write-back of the top.
// When rsp stalls, the response register holds and the request in flight
// waits for it; req stays low until the response slot frees.
// Reset leaves all NUM_BLOCKS blocks free, allocation returning
// NUM_BLOCKS-1 downward; a low mark of the stack depth makes unwritten
// entries read as reset values, so no clearing pass is needed and
// requests are taken right after reset. cfg_wr_en/cfg_wr_data set the
// low watermark (reset 128); write it only while idle (not enforced).
`default_nettype none
module idle_block_allocator_watermark_unit #(
	parameter int NUM_BLOCKS = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ibaw_req_if.sink                         req,
	ibaw_rsp_if.source                       rsp,
	input  wire logic                        cfg_wr_en,
	input  wire logic [ibaw_pkg::WM_W-1:0]   cfg_wr_data
);
	import ibaw_pkg::*;

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam logic [CW-1:0] TOP_FULL = CW'(NUM_BLOCKS);

	state_t          state_q, state_d;
	logic [CW-1:0]   top_q;
	logic [CW-1:0]   min_top_q;
	logic [WM_W-1:0] wm_q;

	cmd_t            cmd_s1;
	logic [AW-1:0]   blk_s1;
	logic            in_range_s1;
	logic            fault_s1;

	logic            accept;
	logic            out_free;
	logic            fire;

	logic [AW-1:0]   stk_rd_addr;
	logic [AW-1:0]   stk_rd_data;
	logic            stk_wr_en;
	logic            map_rd_data;
	logic            map_wr_en;
	logic [AW-1:0]   map_wr_addr;
	logic            map_wr_data;

	logic [CW-1:0]   top_d;
	status_t         status_d;
	logic [IDX_W-1:0] granted_d;
	logic            used;

	logic            out_valid_q;
	status_t         status_q;
	logic [IDX_W-1:0] granted_q;
	logic [FREE_W-1:0] free_q;
	logic            gc_q;

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		fire      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept      = req.valid && req.ready;
	assign stk_rd_addr = AW'(top_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold request payload for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd_t'(req.command);
			blk_s1      <= AW'(req.block_index);
			in_range_s1 <= 32'(req.block_index) < NUM_BLOCKS;
			fault_s1    <= req.fault_hit;
		end
	end

	assign used = map_rd_data && in_range_s1;

	always_comb begin
		top_d       = top_q;
		status_d    = STAT_DONE;
		granted_d   = '0;
		stk_wr_en   = 1'b0;
		map_wr_en   = 1'b0;
		map_wr_addr = blk_s1;
		map_wr_data = 1'b0;
		case (cmd_s1)
			CMD_FREE: begin
				if (used && top_q < TOP_FULL) begin
					stk_wr_en = fire;
					map_wr_en = fire;
					top_d     = top_q + CW'(1);
				end else begin
					status_d = STAT_NOT_USED;
				end
			end
			default: begin
				if (fault_s1) begin
					status_d = STAT_FAULT;
				end else if (top_q == '0) begin
					status_d = STAT_EMPTY;
				end else begin
					top_d       = top_q - CW'(1);
					map_wr_en   = fire;
					map_wr_addr = stk_rd_data;
					map_wr_data = 1'b1;
					granted_d   = IDX_W'(stk_rd_data);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= TOP_FULL;
			min_top_q   <= TOP_FULL;
			wm_q        <= WM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wm_q <= cfg_wr_data;
			end
			if (fire) begin
				top_q <= top_d;
				if (top_d < min_top_q) begin
					min_top_q <= top_d;
				end
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status_d;
			granted_q <= granted_d;
			free_q    <= FREE_W'(top_d);
			gc_q      <= 32'(top_d) <= 32'(wm_q);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_block = granted_q;
	assign rsp.free_blocks   = free_q;
	assign rsp.gc_needed     = gc_q;

	ibaw_free_stack #(
		.DEPTH (NUM_BLOCKS),
		.AW    (AW),
		.CW    (CW)
	) u_stack (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (stk_rd_addr),
		.min_top (min_top_q),
		.rd_data (stk_rd_data),
		.wr_en   (stk_wr_en),
		.wr_addr (AW'(top_q)),
		.wr_data (blk_s1)
	);

	ibaw_use_map #(
		.DEPTH (NUM_BLOCKS),
		.AW    (AW),
		.CW    (CW)
	) u_map (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (AW'(req.block_index)),
		.min_top (min_top_q),
		.rd_data (map_rd_data),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data)
	);
endmodule
`default_nettype wire

// ===== rtl/core/ibaw_free_stack.sv =====
// Free block stack memory; slots below the low mark read as their own index
`default_nettype none
module ibaw_free_stack #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 11
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic [CW-1:0] min_top,
	output logic      [AW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] wr_data
);
	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] mem_q;
	logic [AW-1:0] addr_q;
	logic          fresh_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q   <= mem[rd_addr];
			addr_q  <= rd_addr;
			fresh_q <= CW'(rd_addr) < min_top;
		end
	end

	assign rd_data = fresh_q ? addr_q : mem_q;
endmodule
`default_nettype wire

// ===== rtl/core/ibaw_use_map.sv =====
// In-use bitmap memory; blocks below the low mark read as not in use
`default_nettype none
module ibaw_use_map #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 11
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic [CW-1:0] min_top,
	output logic               rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data
);
	logic mem [DEPTH];
	logic mem_q;
	logic fresh_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q   <= mem[rd_addr];
			fresh_q <= CW'(rd_addr) < min_top;
		end
	end

	assign rd_data = !fresh_q && mem_q;
endmodule
`default_nettype wire
